/* src/ccwc_pkg.sv */
// shared constants, types and the coin table for the coin change way counter
`default_nettype none

package ccwc_pkg;

  // table and count sizing
  localparam int TABLE_DEPTH = 8192;
  localparam int NUM_COINS   = 11;
  localparam int COUNT_WIDTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // fixed field widths
  localparam int CENTS_W = 16;
  localparam int UNITS_W = 14;
  localparam int COIN_W  = 4;
  localparam int OUT_W   = 64;

  // divide by five through a reciprocal: exact over all 16-bit amounts
  localparam logic [31:0] DIV5_MUL   = 32'd52429;
  localparam int          DIV5_SHIFT = 18;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_FILL,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // denominations in five-cent units, 5c up to 100 dollars
  function automatic logic [31:0] coin_units(input logic [COIN_W-1:0] c);
    logic [31:0] v;
    case (c)
      4'd0:    v = 32'd1;
      4'd1:    v = 32'd2;
      4'd2:    v = 32'd4;
      4'd3:    v = 32'd10;
      4'd4:    v = 32'd20;
      4'd5:    v = 32'd40;
      4'd6:    v = 32'd100;
      4'd7:    v = 32'd200;
      4'd8:    v = 32'd400;
      4'd9:    v = 32'd1000;
      4'd10:   v = 32'd2000;
      default: v = 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/ccwc_ram.sv */
// generic ram: one write port, two registered read ports
`default_nettype none

module ccwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]                       rd_data_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]                       rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered reads, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

/* src/coin_change_way_counter.sv */
// coin change way counter: bottom-up count table held in a two-read ram
// sequence: decode, clear of entries 0..units, one fill row per usable coin from v to units,
//   drain, output register; units = amount/5; a zero amount skips fill, a bad one skips clear
// throughput: one amount at a time, the next beat is taken the cycle after the result
//   loads; one table read-modify-write per cycle during fill
// reset: rst_n clears the controller and output valid; the table needs no clearing
//   pass since every query writes each entry before reading it
`default_nettype none

module coin_change_way_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] amount_cents
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata   // [63:0] way_count
);

  localparam int IDX_W = ccwc_pkg::IDX_W;
  localparam int CW    = ccwc_pkg::COUNT_WIDTH;

  ccwc_pkg::state_t state_r, state_nxt;

  logic [ccwc_pkg::CENTS_W-1:0] cents_r;
  logic [IDX_W-1:0]             units_r, idx_r, p1_idx_r;
  logic [ccwc_pkg::COIN_W-1:0]  coin_r;
  logic                         p1_valid_r, fwd_a_r, fwd_b_r;
  logic [CW-1:0]                last_sum_r, res_r;
  logic                         out_valid_r;

  // ram ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [CW-1:0]    wr_data, rd_data_a, rd_data_b;

  // amount decode: divide by five and check the remainder and range
  logic [31:0]                  prod;
  logic [ccwc_pkg::UNITS_W-1:0] units_full;
  logic [ccwc_pkg::CENTS_W-1:0] units_x5;
  logic                         amount_bad;

  assign prod       = 32'(cents_r) * ccwc_pkg::DIV5_MUL;
  assign units_full = prod[31:ccwc_pkg::DIV5_SHIFT];
  assign units_x5   = ccwc_pkg::CENTS_W'({units_full, 2'b00}) +
                      ccwc_pkg::CENTS_W'(units_full);
  assign amount_bad = (units_x5 != cents_r) ||
                      (32'(units_full) >= 32'(ccwc_pkg::TABLE_DEPTH));

  // coin sequencing
  logic [ccwc_pkg::COIN_W-1:0] coin_next;
  logic [IDX_W-1:0]            coin_val, coin_next_val;
  logic                        last_coin, row_end, clear_end, out_free;

  assign coin_val      = IDX_W'(ccwc_pkg::coin_units(coin_r));
  assign coin_next     = ccwc_pkg::COIN_W'(coin_r + 1'b1);
  assign coin_next_val = IDX_W'(ccwc_pkg::coin_units(coin_next));
  assign last_coin     = (32'(coin_next) >= 32'(ccwc_pkg::NUM_COINS)) ||
                         (ccwc_pkg::coin_units(coin_next) > 32'(units_r));
  assign row_end       = (idx_r == units_r);
  assign clear_end     = (idx_r == units_r);
  assign out_free      = !out_valid_r || out_tready;

  // add stage with forwarding of the sum whose write coincides with the read
  logic [CW-1:0] op_a, op_b, sum_c;

  assign op_a  = fwd_a_r ? last_sum_r : rd_data_a;
  assign op_b  = fwd_b_r ? last_sum_r : rd_data_b;
  assign sum_c = op_a + op_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccwc_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ccwc_pkg::ST_DECODE;
      end
      ccwc_pkg::ST_DECODE: begin
        state_nxt = amount_bad ? ccwc_pkg::ST_RESULT : ccwc_pkg::ST_CLEAR;
      end
      ccwc_pkg::ST_CLEAR: begin
        if (clear_end) begin
          state_nxt = (units_r == '0) ? ccwc_pkg::ST_RESULT : ccwc_pkg::ST_FILL;
        end
      end
      ccwc_pkg::ST_FILL: begin
        if (row_end && last_coin) state_nxt = ccwc_pkg::ST_DRAIN;
      end
      ccwc_pkg::ST_DRAIN: begin
        state_nxt = ccwc_pkg::ST_RESULT;
      end
      ccwc_pkg::ST_RESULT: begin
        if (out_free) state_nxt = ccwc_pkg::ST_IDLE;
      end
      default: state_nxt = ccwc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller: handshake and ram ports
  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = p1_idx_r;
    wr_data   = sum_c;
    rd_addr_a = idx_r;
    rd_addr_b = idx_r - coin_val;
    case (state_r)
      ccwc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      ccwc_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = (idx_r == '0) ? CW'(1) : '0;
      end
      ccwc_pkg::ST_FILL, ccwc_pkg::ST_DRAIN: begin
        wr_en = p1_valid_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccwc_pkg::ST_IDLE;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p1_valid_r <= (state_r == ccwc_pkg::ST_FILL);
      if (state_r == ccwc_pkg::ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // issue stage bookkeeping for the add stage
    p1_idx_r <= idx_r;
    fwd_a_r  <= p1_valid_r && (p1_idx_r == rd_addr_a);
    fwd_b_r  <= p1_valid_r && (p1_idx_r == rd_addr_b);
    if (p1_valid_r) last_sum_r <= sum_c;

    case (state_r)
      ccwc_pkg::ST_IDLE: begin
        if (in_tvalid) cents_r <= in_tdata;
      end
      ccwc_pkg::ST_DECODE: begin
        units_r <= IDX_W'(units_full);
        idx_r   <= '0;
        res_r   <= '0;
      end
      ccwc_pkg::ST_CLEAR: begin
        if (clear_end) begin
          idx_r  <= IDX_W'(1);
          coin_r <= '0;
          res_r  <= CW'(1);
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ccwc_pkg::ST_FILL: begin
        if (row_end) begin
          if (!last_coin) begin
            coin_r <= coin_next;
            idx_r  <= coin_next_val;
          end
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ccwc_pkg::ST_DRAIN: begin
        res_r <= sum_c;
      end
      ccwc_pkg::ST_RESULT: begin
        if (out_free) out_tdata <= ccwc_pkg::OUT_W'(res_r);
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

  // count table
  ccwc_ram #(
    .WIDTH (CW),
    .DEPTH (ccwc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // add stage only follows a fill issue cycle
  a_p1_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> $past(state_r == ccwc_pkg::ST_FILL))
    else $error("add stage active without a fill issue");

  // no table write beyond the current amount
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr <= units_r))
    else $error("table write beyond the amount");

  // fill never rewrites entry zero
  a_fill_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> (p1_idx_r != '0))
    else $error("fill wrote entry zero");

  // drain is followed directly by the result
  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccwc_pkg::ST_DRAIN) |=> (state_r == ccwc_pkg::ST_RESULT))
    else $error("drain not followed by result");

endmodule

`default_nettype wire
